/* hdl/ths_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ths_pkg
// Shared types, constants and helpers for the timer heap scheduler.
// ----------------------------------------------------------------------------
package ths_pkg;

	localparam int MAX_TIMERS = 64;
	localparam int HW         = 6;   // handle / heap position width
	localparam int CW         = 7;   // count width, holds MAX_TIMERS itself
	localparam int TW         = 32;  // tick time width
	localparam int TPM_W      = 20;  // ticks_per_ms width

	localparam logic [2:0] OP_ADD      = 3'd0;
	localparam logic [2:0] OP_DELETE   = 3'd1;
	localparam logic [2:0] OP_RESCHED  = 3'd2;
	localparam logic [2:0] OP_SET_IVAL = 3'd3;
	localparam logic [2:0] OP_CHECK    = 3'd4;
	localparam logic [2:0] OP_COMPLETE = 3'd5;

	localparam logic [2:0] STS_OK       = 3'd0;
	localparam logic [2:0] STS_BAD_IVAL = 3'd1;
	localparam logic [2:0] STS_NO_SLOT  = 3'd2;
	localparam logic [2:0] STS_INACTIVE = 3'd3;
	localparam logic [2:0] STS_EMPTY    = 3'd4;

	localparam logic CFG_TPM    = 1'b0;
	localparam logic CFG_MAX_IV = 1'b1;

	// free stack control request
	typedef struct packed {
		logic          pop;
		logic          push;
		logic [HW-1:0] push_h;
	} fs_ctl_t;

	// time to expiry relative to a reference, zero when already past
	function automatic logic [TW-1:0] tte(input logic [TW-1:0] e, input logic [TW-1:0] r);
		logic [TW-1:0] d;
		d = e - r;
		return d[TW-1] ? '0 : d;
	endfunction

endpackage

/* hdl/ths_free_stack.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ths_free_stack
// LIFO of free timer handles in a synchronous memory; entries never written
// since reset read back their reset value through a low-water mark.
// ----------------------------------------------------------------------------
module ths_free_stack (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ths_pkg::fs_ctl_t        ctl,
	output logic [ths_pkg::HW-1:0]  pop_handle,
	output logic [ths_pkg::CW-1:0]  count
);
	import ths_pkg::*;

	logic [HW-1:0] stack_m [MAX_TIMERS];
	logic [CW-1:0] fc_q;
	logic [CW-1:0] min_q;
	logic [HW-1:0] idx;
	logic [HW-1:0] rd_s1;
	logic [HW-1:0] rstv_s1;
	logic          use_rst_s1;

	assign idx = HW'(fc_q - CW'(1));

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			stack_m[fc_q[HW-1:0]] <= ctl.push_h;
		end
		if (ctl.pop) begin
			rd_s1      <= stack_m[idx];
			rstv_s1    <= HW'(MAX_TIMERS - 1) - idx;
			use_rst_s1 <= {1'b0, idx} < min_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q  <= CW'(MAX_TIMERS);
			min_q <= CW'(MAX_TIMERS);
		end else if (ctl.pop) begin
			fc_q <= fc_q - CW'(1);
			if ({1'b0, idx} < min_q) begin
				min_q <= {1'b0, idx};
			end
		end else if (ctl.push) begin
			fc_q <= fc_q + CW'(1);
		end
	end

	assign pop_handle = use_rst_s1 ? rstv_s1 : rd_s1;
	assign count      = fc_q;

endmodule

/* hdl/timer_heap_scheduler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_heap_scheduler
// Binary min-heap of timers keyed by wrapping tick expiry times.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_*) takes one request per handshake: tuser holds the
//   operation, tdata the tick time, handle, interval and rearm flag.
//   Master stream (m_*) returns exactly one result per request: tuser holds
//   the status, tdata the handle, expired flag, ticks to expire and count.
//   The cfg channel writes ticks_per_ms (index 0) and max_interval_ms
//   (index 1); write it only while no request is in flight.
//   One request is worked at a time. Sifting up reads one parent per heap
//   level; sifting down reads the left and, if present, the right child,
//   all through the single read port of the heap slot memory. Every memory
//   has a registered read.
//   s_tready is high whenever the sequencer is idle, also while a result
//   waits in the output register; a stalled receiver holds the result and
//   the next request stops only at its final step.
//   Reset empties the heap and restocks the free stack at once (no sweep).
// ----------------------------------------------------------------------------
module timer_heap_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // now_ticks[31:0], timer_handle[37:32],
	                              // interval_ms[69:38], rearm[70], zero pad
	input  logic [2:0]  s_tuser,  // operation
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // result_handle[5:0], head_expired[6],
	                              // ticks_to_expire[38:7], active_count[45:39]
	output logic [2:0]  m_tuser,  // status
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	import ths_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_DECODE, S_ADD_POP, S_RM_A, S_RM_B, S_RM_POST, S_INS_MUL,
		S_INS_ADD, S_UP_CHK, S_UP_RD, S_UP_CMP, S_DN_CHK, S_DN_L1, S_DN_L2,
		S_DN_R1, S_DN_R2, S_DN_DEC, S_PLACE, S_CHK_A, S_CHK_B, S_DONE
	} state_t;

	state_t st_q;

	// configuration
	logic [TPM_W-1:0] tpm_q;
	logic [TW-1:0]    max_iv_q;

	// latched request
	logic [2:0]    op_q;
	logic [TW-1:0] now_q;
	logic [HW-1:0] h_q;
	logic [TW-1:0] iv_q;
	logic          rearm_q;

	// heap control and working registers
	logic [CW-1:0]         size_q;
	logic [MAX_TIMERS-1:0] active_q;
	logic                  ins_phase_q;
	logic [HW-1:0]         pos_q;
	logic [HW-1:0]         item_q;
	logic [TW-1:0]         ie_q;
	logic [TW-1:0]         iep_q;
	logic [TW-1:0]         hexp_q;
	logic [TW-1:0]         hep_q;
	logic [TW-1:0]         per_q;
	logic [TW-1:0]         prod_q;
	logic [HW-1:0]         ph_q;
	logic [HW-1:0]         sh_q;
	logic [TW-1:0]         she_q;
	logic [TW-1:0]         shep_q;
	logic [HW-1:0]         sp_q;
	logic [HW-1:0]         cand_q;

	// pending result
	logic [2:0]    sts_q;
	logic [HW-1:0] rh_q;
	logic          hx_q;
	logic [TW-1:0] tk_q;

	// output register
	logic          m_tvalid_q;
	logic [2:0]    out_sts_q;
	logic [HW-1:0] out_rh_q;
	logic          out_hx_q;
	logic [TW-1:0] out_tk_q;
	logic [CW-1:0] out_cnt_q;

	// memories: heap slot by position, records by handle
	logic [HW-1:0] slot_m  [MAX_TIMERS];
	logic [HW-1:0] hpos_m  [MAX_TIMERS];
	logic [TW-1:0] exp_m   [MAX_TIMERS];
	logic [TW-1:0] epoch_m [MAX_TIMERS];
	logic [TW-1:0] per_m   [MAX_TIMERS];

	logic [HW-1:0] sl_raddr, sl_rdata, sl_waddr, sl_wdata;
	logic          sl_we;
	logic [HW-1:0] hp_rdata, hp_waddr, hp_wdata;
	logic          hp_we;
	logic [HW-1:0] rec_raddr, rec_waddr;
	logic [TW-1:0] ex_rdata, ex_wdata, ep_rdata, pe_rdata;
	logic          ex_we, ep_we, pe_we;

	// free stack
	fs_ctl_t       fs_ctl;
	logic [HW-1:0] fs_handle;
	logic [CW-1:0] fs_count;

	// derived values
	logic          accept;
	logic          live;
	logic          bad_iv;
	logic [HW-1:0] par;
	logic [7:0]    lft, rgt, size8;
	logic [51:0]   prod_full;
	logic [TW-1:0] ins_exp;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (st_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign live      = active_q[h_q];
	assign bad_iv    = (iv_q == '0) || (iv_q > max_iv_q);
	assign par       = (pos_q - HW'(1)) >> 1;
	assign lft       = {1'b0, pos_q, 1'b1};
	assign rgt       = lft + 8'd1;
	assign size8     = {1'b0, size_q};
	assign prod_full = 52'(per_q) * 52'(tpm_q);
	assign ins_exp   = now_q + prod_q;

	ths_free_stack u_free (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (fs_ctl),
		.pop_handle (fs_handle),
		.count      (fs_count)
	);

	// memory port steering
	always_comb begin
		sl_raddr  = '0;
		sl_we     = 1'b0;
		sl_waddr  = pos_q;
		sl_wdata  = item_q;
		hp_we     = 1'b0;
		hp_waddr  = item_q;
		hp_wdata  = pos_q;
		rec_raddr = (st_q == S_DECODE) ? h_q : sl_rdata;
		rec_waddr = (st_q == S_ADD_POP) ? fs_handle : h_q;
		ex_we     = 1'b0;
		ex_wdata  = ins_exp;
		ep_we     = 1'b0;
		pe_we     = 1'b0;
		fs_ctl    = '0;
		fs_ctl.push_h = h_q;
		case (st_q)
			S_DECODE: begin
				sl_raddr = (op_q == OP_CHECK) ? '0 : HW'(size_q - CW'(1));
				if (op_q == OP_ADD && !bad_iv && fs_count != '0) begin
					fs_ctl.pop = 1'b1;
				end
			end
			S_ADD_POP: begin
				ep_we = 1'b1;
				pe_we = 1'b1;
			end
			S_RM_POST: begin
				if (op_q == OP_DELETE || (op_q == OP_COMPLETE && !rearm_q)) begin
					fs_ctl.push = 1'b1;
				end else begin
					ep_we = 1'b1;
					pe_we = (op_q == OP_SET_IVAL);
				end
			end
			S_INS_ADD: ex_we = 1'b1;
			S_UP_CHK:  sl_raddr = par;
			S_UP_CMP: begin
				if (tte(ex_rdata, iep_q) > tte(ie_q, iep_q)) begin
					sl_we    = 1'b1;
					sl_wdata = ph_q;
					hp_we    = 1'b1;
					hp_waddr = ph_q;
				end
			end
			S_DN_CHK: sl_raddr = lft[HW-1:0];
			S_DN_L2:  sl_raddr = rgt[HW-1:0];
			S_DN_DEC: begin
				if (sp_q != pos_q) begin
					sl_we    = 1'b1;
					sl_wdata = sh_q;
					hp_we    = 1'b1;
					hp_waddr = sh_q;
				end
			end
			S_PLACE: begin
				sl_we = 1'b1;
				hp_we = 1'b1;
			end
			default: ;
		endcase
	end

	// heap slot memory and handle record memories
	always_ff @(posedge clk) begin
		sl_rdata <= slot_m[sl_raddr];
		if (sl_we) begin
			slot_m[sl_waddr] <= sl_wdata;
		end
	end

	always_ff @(posedge clk) begin
		hp_rdata <= hpos_m[h_q];
		ex_rdata <= exp_m[rec_raddr];
		ep_rdata <= epoch_m[rec_raddr];
		pe_rdata <= per_m[h_q];
		if (hp_we) begin
			hpos_m[hp_waddr] <= hp_wdata;
		end
		if (ex_we) begin
			exp_m[h_q] <= ex_wdata;
		end
		if (ep_we) begin
			epoch_m[rec_waddr] <= now_q;
		end
		if (pe_we) begin
			per_m[rec_waddr] <= iv_q;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpm_q    <= TPM_W'(1);
			max_iv_q <= TW'(3600000);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TPM:    tpm_q    <= cfg_data[TPM_W-1:0];
				CFG_MAX_IV: max_iv_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			size_q      <= '0;
			active_q    <= '0;
			ins_phase_q <= 1'b0;
			op_q        <= '0;
			now_q       <= '0;
			h_q         <= '0;
			iv_q        <= '0;
			rearm_q     <= 1'b0;
			pos_q       <= '0;
			item_q      <= '0;
			ie_q        <= '0;
			iep_q       <= '0;
			hexp_q      <= '0;
			hep_q       <= '0;
			per_q       <= '0;
			prod_q      <= '0;
			ph_q        <= '0;
			sh_q        <= '0;
			she_q       <= '0;
			shep_q      <= '0;
			sp_q        <= '0;
			cand_q      <= '0;
			sts_q       <= STS_OK;
			rh_q        <= '0;
			hx_q        <= 1'b0;
			tk_q        <= '0;
			m_tvalid_q  <= 1'b0;
			out_sts_q   <= STS_OK;
			out_rh_q    <= '0;
			out_hx_q    <= 1'b0;
			out_tk_q    <= '0;
			out_cnt_q   <= '0;
		end else begin
			// drop the result once taken, unless a new one is loaded below
			if (m_tready && st_q != S_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (accept) begin
						op_q    <= s_tuser;
						now_q   <= s_tdata[31:0];
						h_q     <= s_tdata[37:32];
						iv_q    <= s_tdata[69:38];
						rearm_q <= s_tdata[70];
						sts_q   <= STS_OK;
						rh_q    <= '0;
						hx_q    <= 1'b0;
						tk_q    <= '0;
						st_q    <= S_DECODE;
					end
				end
				S_DECODE: begin
					ins_phase_q <= 1'b0;
					case (op_q)
						OP_ADD: begin
							if (bad_iv) begin
								sts_q <= STS_BAD_IVAL;
								st_q  <= S_DONE;
							end else if (fs_count == '0) begin
								sts_q <= STS_NO_SLOT;
								st_q  <= S_DONE;
							end else begin
								st_q <= S_ADD_POP;
							end
						end
						OP_DELETE, OP_RESCHED, OP_COMPLETE: begin
							if (!live) begin
								sts_q <= STS_INACTIVE;
								st_q  <= S_DONE;
							end else begin
								st_q <= S_RM_A;
							end
						end
						OP_SET_IVAL: begin
							if (bad_iv) begin
								sts_q <= STS_BAD_IVAL;
								st_q  <= S_DONE;
							end else if (!live) begin
								sts_q <= STS_INACTIVE;
								st_q  <= S_DONE;
							end else begin
								st_q <= S_RM_A;
							end
						end
						OP_CHECK: begin
							if (size_q == '0) begin
								sts_q <= STS_EMPTY;
								tk_q  <= '1;
								st_q  <= S_DONE;
							end else begin
								st_q <= S_CHK_A;
							end
						end
						default: st_q <= S_DONE;
					endcase
				end
				// new handle arrives from the free stack
				S_ADD_POP: begin
					h_q                 <= fs_handle;
					rh_q                <= fs_handle;
					active_q[fs_handle] <= 1'b1;
					per_q               <= iv_q;
					ins_phase_q         <= 1'b1;
					st_q                <= S_INS_MUL;
				end
				// position, last slot and record of the handle are read
				S_RM_A: begin
					pos_q  <= hp_rdata;
					item_q <= sl_rdata;
					hexp_q <= ex_rdata;
					hep_q  <= ep_rdata;
					per_q  <= (op_q == OP_SET_IVAL) ? iv_q : pe_rdata;
					size_q <= size_q - CW'(1);
					st_q   <= S_RM_B;
				end
				// order the replacement against the removed timer
				S_RM_B: begin
					ie_q  <= ex_rdata;
					iep_q <= ep_rdata;
					if ({1'b0, pos_q} >= size_q) begin
						st_q <= S_RM_POST;
					end else if (tte(ex_rdata, hep_q) < tte(hexp_q, hep_q)) begin
						st_q <= S_UP_CHK;
					end else if (tte(ex_rdata, hep_q) > tte(hexp_q, hep_q)) begin
						st_q <= S_DN_CHK;
					end else begin
						st_q <= S_PLACE;
					end
				end
				S_RM_POST: begin
					if (op_q == OP_DELETE || (op_q == OP_COMPLETE && !rearm_q)) begin
						active_q[h_q] <= 1'b0;
						st_q          <= S_DONE;
					end else begin
						ins_phase_q <= 1'b1;
						st_q        <= S_INS_MUL;
					end
				end
				S_INS_MUL: begin
					prod_q <= prod_full[TW-1:0];
					st_q   <= S_INS_ADD;
				end
				S_INS_ADD: begin
					item_q <= h_q;
					ie_q   <= ins_exp;
					iep_q  <= now_q;
					pos_q  <= size_q[HW-1:0];
					size_q <= size_q + CW'(1);
					st_q   <= S_UP_CHK;
				end
				S_UP_CHK: begin
					st_q <= (pos_q == '0) ? S_PLACE : S_UP_RD;
				end
				S_UP_RD: begin
					ph_q <= sl_rdata;
					st_q <= S_UP_CMP;
				end
				// move the parent down or stop
				S_UP_CMP: begin
					if (tte(ex_rdata, iep_q) <= tte(ie_q, iep_q)) begin
						st_q <= S_PLACE;
					end else begin
						pos_q <= par;
						st_q  <= S_UP_CHK;
					end
				end
				S_DN_CHK: begin
					if (lft >= size8) begin
						st_q <= S_PLACE;
					end else begin
						sh_q   <= item_q;
						she_q  <= ie_q;
						shep_q <= iep_q;
						sp_q   <= pos_q;
						st_q   <= S_DN_L1;
					end
				end
				S_DN_L1: begin
					cand_q <= sl_rdata;
					st_q   <= S_DN_L2;
				end
				S_DN_L2: begin
					if (tte(ex_rdata, shep_q) < tte(she_q, shep_q)) begin
						sh_q   <= cand_q;
						she_q  <= ex_rdata;
						shep_q <= ep_rdata;
						sp_q   <= lft[HW-1:0];
					end
					st_q <= (rgt < size8) ? S_DN_R1 : S_DN_DEC;
				end
				S_DN_R1: begin
					cand_q <= sl_rdata;
					st_q   <= S_DN_R2;
				end
				S_DN_R2: begin
					if (tte(ex_rdata, shep_q) < tte(she_q, shep_q)) begin
						sh_q <= cand_q;
						sp_q <= rgt[HW-1:0];
					end
					st_q <= S_DN_DEC;
				end
				S_DN_DEC: begin
					if (sp_q == pos_q) begin
						st_q <= S_PLACE;
					end else begin
						pos_q <= sp_q;
						st_q  <= S_DN_CHK;
					end
				end
				S_PLACE: begin
					st_q <= ins_phase_q ? S_DONE : S_RM_POST;
				end
				S_CHK_A: begin
					rh_q <= sl_rdata;
					st_q <= S_CHK_B;
				end
				S_CHK_B: begin
					tk_q <= tte(ex_rdata, now_q);
					hx_q <= (tte(ex_rdata, now_q) == '0);
					st_q <= S_DONE;
				end
				// hold until the output register is free
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						out_sts_q  <= sts_q;
						out_rh_q   <= rh_q;
						out_hx_q   <= hx_q;
						out_tk_q   <= tk_q;
						out_cnt_q  <= size_q;
						st_q       <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_sts_q;
	assign m_tdata  = {2'b00, out_cnt_q, out_tk_q, out_hx_q, out_rh_q};

	// heap never outgrows its storage
	a_size_bound: assert property (@(posedge clk) disable iff (!arst_n)
		size_q <= CW'(MAX_TIMERS))
		else $error("heap size above capacity");

	// every handle is either free or in the heap between requests
	a_handle_conserved: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_IDLE) |-> (8'(size_q) + 8'(fs_count) == 8'(MAX_TIMERS)))
		else $error("free count and heap size disagree");

	// active bits match the heap population between requests
	a_active_count: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_IDLE) |-> ($countones(active_q) == 32'(size_q)))
		else $error("active handles do not match heap size");

	// a placed entry always lands inside the heap
	a_place_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_PLACE) |-> ({1'b0, pos_q} < size_q))
		else $error("placement outside heap");

endmodule
